FILE: rtl/core/hkr_pkg.sv
`timescale 1ns / 1ps

package hkr_pkg;

    // Alphabet size and reciprocal used for reduction by multiplication
    localparam int LETTERS    = 26;
    localparam int RECIP      = 2521;   // ceil(2^16 / 26)
    localparam int RECIP_SHIFT = 16;

    typedef logic [4:0]  t_let;     // letter value 0..25
    typedef logic [9:0]  t_prod;    // product of two letters
    typedef logic [10:0] t_sum;     // sum of two products

    // Reduce a 5-bit field into 0..25 (26..31 wrap to 0..5)
    function automatic t_let red5(input t_let v);
        if (v >= t_let'(LETTERS)) begin
            return v - t_let'(LETTERS);
        end
        return v;
    endfunction

    // Reduce an 11-bit value modulo 26 by reciprocal multiplication; the
    // quotient estimate is exact over the whole 11-bit range
    function automatic t_let mod26(input t_sum v);
        logic [22:0] prod;
        logic [6:0]  q;
        t_sum        r;
        prod = {12'd0, v} * 23'(RECIP);
        q    = prod[RECIP_SHIFT+6:RECIP_SHIFT];
        r    = v - t_sum'(q) * t_sum'(LETTERS);
        return r[4:0];
    endfunction

    // Inverse modulo 26; zero marks a residue with no inverse
    function automatic t_let inv26(input t_let d);
        t_let res;
        unique case (d)
            5'd1:    res = 5'd1;
            5'd3:    res = 5'd9;
            5'd5:    res = 5'd21;
            5'd7:    res = 5'd15;
            5'd9:    res = 5'd3;
            5'd11:   res = 5'd19;
            5'd15:   res = 5'd7;
            5'd17:   res = 5'd23;
            5'd19:   res = 5'd11;
            5'd21:   res = 5'd5;
            5'd23:   res = 5'd17;
            5'd25:   res = 5'd25;
            default: res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/hill_key_recovery_2x2_mod26_unit.sv
`timescale 1ns / 1ps

// Hill cipher 2x2 key recovery modulo 26.
// Input channel: i_valid / o_ready with the plaintext matrix i_plain_* and
// the ciphertext matrix i_cipher_*, one letter value per 5-bit port.
// Output channel: o_valid / i_ready with the key matrix o_key_* and
// o_not_invertible; keys are zero when the plaintext determinant has no
// inverse modulo 26. Field values 26..31 act as their residue mod 26.
// Throughput: one matrix pair per cycle while o_ready is high. There are six
// register stages; the input transfer loads the first, and they hold in order:
// residue and determinant products, determinant, inverse lookup and
// adjugate products, inverse reduction, key products, key reduction.
// Each stage advances when it is empty or the stage after it advances, so
// a stalled receiver fills the pipe and o_ready falls only when all six
// stages hold items; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all stage valid bits; the block
// takes an item in the first cycle after reset is released.
module hill_key_recovery_2x2_mod26_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  hkr_pkg::t_let i_plain_00,
    input  hkr_pkg::t_let i_plain_01,
    input  hkr_pkg::t_let i_plain_10,
    input  hkr_pkg::t_let i_plain_11,
    input  hkr_pkg::t_let i_cipher_00,
    input  hkr_pkg::t_let i_cipher_01,
    input  hkr_pkg::t_let i_cipher_10,
    input  hkr_pkg::t_let i_cipher_11,
    output logic         o_valid,
    input  logic         i_ready,
    output hkr_pkg::t_let o_key_00,
    output hkr_pkg::t_let o_key_01,
    output hkr_pkg::t_let o_key_10,
    output hkr_pkg::t_let o_key_11,
    output logic         o_not_invertible
);
    import hkr_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    // Stage 1: residues and determinant products
    t_let  r1_p00, r1_p01, r1_p10, r1_p11;
    t_let  r1_c00, r1_c01, r1_c10, r1_c11;
    t_prod r1_a, r1_b;
    // Stage 2: determinant and negated off-diagonal entries
    t_let  r2_det, r2_p00, r2_n01, r2_n10, r2_p11;
    t_let  r2_c00, r2_c01, r2_c10, r2_c11;
    // Stage 3: adjugate times determinant inverse, unreduced
    t_prod r3_m00, r3_m01, r3_m10, r3_m11;
    logic  r3_sing;
    t_let  r3_c00, r3_c01, r3_c10, r3_c11;
    // Stage 4: inverse matrix
    t_let  r4_i00, r4_i01, r4_i10, r4_i11;
    logic  r4_sing;
    t_let  r4_c00, r4_c01, r4_c10, r4_c11;
    // Stage 5: key sums, unreduced
    t_sum  r5_s00, r5_s01, r5_s10, r5_s11;
    logic  r5_sing;
    // Stage 6: output register
    t_let  r6_k00, r6_k01, r6_k10, r6_k11;
    logic  r6_sing;

    t_let  n_p00, n_p01, n_p10, n_p11;
    t_let  n_a, n_b, n_dinv;
    logic [5:0] n_dsum;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: reduce fields and form determinant products
    always_comb begin
        n_p00 = red5(i_plain_00);
        n_p01 = red5(i_plain_01);
        n_p10 = red5(i_plain_10);
        n_p11 = red5(i_plain_11);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_p00 <= n_p00;
            r1_p01 <= n_p01;
            r1_p10 <= n_p10;
            r1_p11 <= n_p11;
            r1_c00 <= red5(i_cipher_00);
            r1_c01 <= red5(i_cipher_01);
            r1_c10 <= red5(i_cipher_10);
            r1_c11 <= red5(i_cipher_11);
            r1_a   <= t_prod'(n_p00) * t_prod'(n_p11);
            r1_b   <= t_prod'(n_p01) * t_prod'(n_p10);
        end
    end

    // Stage 2: determinant mod 26 and negated entries of the adjugate
    always_comb begin
        n_a    = mod26(t_sum'(r1_a));
        n_b    = mod26(t_sum'(r1_b));
        n_dsum = 6'(n_a) + 6'(LETTERS) - 6'(n_b);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_det <= (n_dsum >= 6'(LETTERS)) ? 5'(n_dsum - 6'(LETTERS)) : n_dsum[4:0];
            r2_p00 <= r1_p00;
            r2_p11 <= r1_p11;
            r2_n01 <= (r1_p01 == '0) ? '0 : t_let'(LETTERS) - r1_p01;
            r2_n10 <= (r1_p10 == '0) ? '0 : t_let'(LETTERS) - r1_p10;
            r2_c00 <= r1_c00;
            r2_c01 <= r1_c01;
            r2_c10 <= r1_c10;
            r2_c11 <= r1_c11;
        end
    end

    // Stage 3: look up determinant inverse and scale the adjugate
    assign n_dinv = inv26(r2_det);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_m00  <= t_prod'(r2_p11) * t_prod'(n_dinv);
            r3_m01  <= t_prod'(r2_n01) * t_prod'(n_dinv);
            r3_m10  <= t_prod'(r2_n10) * t_prod'(n_dinv);
            r3_m11  <= t_prod'(r2_p00) * t_prod'(n_dinv);
            r3_sing <= (n_dinv == '0);
            r3_c00  <= r2_c00;
            r3_c01  <= r2_c01;
            r3_c10  <= r2_c10;
            r3_c11  <= r2_c11;
        end
    end

    // Stage 4: reduce the inverse matrix
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_i00  <= mod26(t_sum'(r3_m00));
            r4_i01  <= mod26(t_sum'(r3_m01));
            r4_i10  <= mod26(t_sum'(r3_m10));
            r4_i11  <= mod26(t_sum'(r3_m11));
            r4_sing <= r3_sing;
            r4_c00  <= r3_c00;
            r4_c01  <= r3_c01;
            r4_c10  <= r3_c10;
            r4_c11  <= r3_c11;
        end
    end

    // Stage 5: multiply inverse by ciphertext matrix
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_s00  <= t_sum'(t_prod'(r4_i00) * t_prod'(r4_c00))
                     + t_sum'(t_prod'(r4_i01) * t_prod'(r4_c10));
            r5_s01  <= t_sum'(t_prod'(r4_i00) * t_prod'(r4_c01))
                     + t_sum'(t_prod'(r4_i01) * t_prod'(r4_c11));
            r5_s10  <= t_sum'(t_prod'(r4_i10) * t_prod'(r4_c00))
                     + t_sum'(t_prod'(r4_i11) * t_prod'(r4_c10));
            r5_s11  <= t_sum'(t_prod'(r4_i10) * t_prod'(r4_c01))
                     + t_sum'(t_prod'(r4_i11) * t_prod'(r4_c11));
            r5_sing <= r4_sing;
        end
    end

    // Stage 6: reduce keys, zero them for a singular plaintext
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_k00  <= r5_sing ? '0 : mod26(r5_s00);
            r6_k01  <= r5_sing ? '0 : mod26(r5_s01);
            r6_k10  <= r5_sing ? '0 : mod26(r5_s10);
            r6_k11  <= r5_sing ? '0 : mod26(r5_s11);
            r6_sing <= r5_sing;
        end
    end

    assign o_valid          = r_v[NSTG-1];
    assign o_key_00         = r6_k00;
    assign o_key_01         = r6_k01;
    assign o_key_10         = r6_k10;
    assign o_key_11         = r6_k11;
    assign o_not_invertible = r6_sing;

`ifndef NO_ASSERTIONS
    // Input stalls only when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v) && !i_ready)
        else $error("input stalled with a free pipeline slot");

    // A singular result carries all-zero keys
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_not_invertible |->
            o_key_00 == '0 && o_key_01 == '0 && o_key_10 == '0 && o_key_11 == '0)
        else $error("singular result with nonzero key");

    // Delivered keys are reduced letter values
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_key_00 < 5'd26 && o_key_01 < 5'd26
                 && o_key_10 < 5'd26 && o_key_11 < 5'd26)
        else $error("key entry out of range");

    // An item in the output stage waits there while the receiver stalls
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result lost under stall");
`endif

endmodule
